### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the top RTL file of the sort block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define QSH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QSH_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

### hw/rtl/qsh_pkg.sv
// ----------------------------------------------------------------------------
// qsh_pkg
// Types and constants shared by the quicksort sequencer and its datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qsh_pkg;

    localparam int QSH_DEPTH      = 64;
    localparam int QSH_DATA_WIDTH = 32;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_START,
        ST_POP,
        ST_RANGE,
        ST_KEY,
        ST_SCAN_I,
        ST_SCAN_J,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_PUSH_A,
        ST_PUSH_B,
        ST_OUT_LOAD,
        ST_OUT_HOLD
    } qsh_state_t;

    // element store read address source
    typedef enum logic [2:0] {
        SRD_MID,
        SRD_I,
        SRD_I_INC,
        SRD_J,
        SRD_J_DEC,
        SRD_K,
        SRD_K_INC
    } qsh_srd_t;

    // element store write source
    typedef enum logic [1:0] {
        SWR_IN,
        SWR_I,
        SWR_J
    } qsh_swr_t;

    // range stack write source
    typedef enum logic [1:0] {
        KWR_FULL,
        KWR_UPPER,
        KWR_LOWER
    } qsh_kwr_t;

    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic room;
        logic cnt_ge2;
        logic stk_empty;
        logic range_short;
        logic i_adv;
        logic j_adv;
        logic not_crossed;
        logic swap_more;
        logic upper_ok;
        logic lower_ok;
        logic out_fire;
        logic out_last;
    } qsh_stat_t;

    typedef struct packed {
        logic     in_ready;
        logic     out_valid;
        qsh_srd_t st_rsel;
        logic     st_we;
        qsh_swr_t st_wsel;
        logic     stk_we;
        qsh_kwr_t stk_wsel;
        logic     cnt_inc;
        logic     drop_set;
        logic     sp_inc;
        logic     sp_dec;
        logic     ld_range;
        logic     ld_key;
        logic     i_inc;
        logic     j_dec;
        logic     ld_a;
        logic     ld_b;
        logic     ld_out;
        logic     k_inc;
        logic     clr_set;
    } qsh_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/qsh_ram.sv
// ----------------------------------------------------------------------------
// qsh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/qsh_ctrl.sv
// ----------------------------------------------------------------------------
// qsh_ctrl
// Sequencer: collect, partition loop over the range stack, and emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qsh_ctrl
    import qsh_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire qsh_stat_t stat,
    output qsh_ctl_t       ctl
);

    qsh_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                if (stat.in_fire && stat.in_last) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = stat.cnt_ge2 ? ST_POP : ST_OUT_LOAD;
            end
            ST_POP: begin
                state_next = stat.stk_empty ? ST_OUT_LOAD : ST_RANGE;
            end
            ST_RANGE: begin
                state_next = stat.range_short ? ST_POP : ST_KEY;
            end
            ST_KEY: begin
                state_next = ST_SCAN_I;
            end
            ST_SCAN_I: begin
                if (!stat.i_adv) begin
                    state_next = ST_SCAN_J;
                end
            end
            ST_SCAN_J: begin
                if (!stat.j_adv) begin
                    state_next = stat.not_crossed ? ST_SWAP_A : ST_PUSH_A;
                end
            end
            ST_SWAP_A: begin
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                state_next = stat.swap_more ? ST_SCAN_I : ST_PUSH_A;
            end
            ST_PUSH_A: begin
                state_next = ST_PUSH_B;
            end
            ST_PUSH_B: begin
                state_next = ST_POP;
            end
            ST_OUT_LOAD: begin
                state_next = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (stat.out_fire) begin
                    state_next = stat.out_last ? ST_COLLECT : ST_OUT_LOAD;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb begin
        ctl = '0;
        ctl.st_rsel  = SRD_K;
        ctl.st_wsel  = SWR_IN;
        ctl.stk_wsel = KWR_FULL;
        unique case (state_reg)
            ST_COLLECT: begin
                ctl.in_ready = 1'b1;
                ctl.st_wsel  = SWR_IN;
                ctl.st_we    = stat.in_fire && stat.room;
                ctl.cnt_inc  = stat.in_fire && stat.room;
                ctl.drop_set = stat.in_fire && !stat.room;
            end
            ST_START: begin
                ctl.stk_wsel = KWR_FULL;
                ctl.stk_we   = stat.cnt_ge2;
                ctl.sp_inc   = stat.cnt_ge2;
                ctl.st_rsel  = SRD_K;
            end
            ST_POP: begin
                // stack read address is sp - 1 at all times
                ctl.sp_dec  = !stat.stk_empty;
                ctl.st_rsel = SRD_K;
            end
            ST_RANGE: begin
                ctl.ld_range = 1'b1;
                ctl.st_rsel  = SRD_MID;
            end
            ST_KEY: begin
                ctl.ld_key  = 1'b1;
                ctl.st_rsel = SRD_I;
            end
            ST_SCAN_I: begin
                if (stat.i_adv) begin
                    ctl.i_inc   = 1'b1;
                    ctl.st_rsel = SRD_I_INC;
                end else begin
                    ctl.ld_a    = 1'b1;
                    ctl.st_rsel = SRD_J;
                end
            end
            ST_SCAN_J: begin
                if (stat.j_adv) begin
                    ctl.j_dec   = 1'b1;
                    ctl.st_rsel = SRD_J_DEC;
                end else begin
                    ctl.ld_b = 1'b1;
                end
            end
            ST_SWAP_A: begin
                ctl.st_we   = 1'b1;
                ctl.st_wsel = SWR_I;
            end
            ST_SWAP_B: begin
                ctl.st_we   = 1'b1;
                ctl.st_wsel = SWR_J;
                ctl.i_inc   = 1'b1;
                ctl.j_dec   = 1'b1;
                ctl.st_rsel = SRD_I_INC;
            end
            ST_PUSH_A: begin
                ctl.stk_wsel = KWR_UPPER;
                ctl.stk_we   = stat.upper_ok;
                ctl.sp_inc   = stat.upper_ok;
            end
            ST_PUSH_B: begin
                ctl.stk_wsel = KWR_LOWER;
                ctl.stk_we   = stat.lower_ok;
                ctl.sp_inc   = stat.lower_ok;
            end
            ST_OUT_LOAD: begin
                ctl.ld_out = 1'b1;
            end
            ST_OUT_HOLD: begin
                ctl.out_valid = 1'b1;
                if (stat.out_fire) begin
                    ctl.k_inc   = !stat.out_last;
                    ctl.clr_set = stat.out_last;
                    ctl.st_rsel = SRD_K_INC;
                end
            end
            default: begin
                ctl.in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/quicksort_hoare_block.sv
// Collects signed values, one item per cycle, until an item with tlast; items
// beyond DEPTH are dropped and flag every result of that set in tuser. The set
// is then sorted in place by quicksort (middle pivot, two-index Hoare
// partition, explicit stack of index ranges) and streamed out ascending, with
// tlast on the largest value. Sorting works through one element-store read
// port whose data is compared against the pivot: a compare reads one element,
// a swap writes the two elements back in turn, and a range popped from the
// stack is dropped if too short to split, else its pivot is read before its
// scans start. Each result is registered before it is offered. Input is not
// ready from the final item until the last result has been taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// quicksort_hoare_block
// Element store, range stack and index datapath around the sort sequencer.
// ----------------------------------------------------------------------------
module quicksort_hoare_block
    import qsh_pkg::*;
#(
    parameter int DEPTH      = QSH_DEPTH,
    parameter int DATA_WIDTH = QSH_DATA_WIDTH,
    localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [TDATA_W-1:0] s_axis_tdata,   // [DATA_WIDTH-1:0] data_value
    input  wire logic               s_axis_tlast,   // final_item
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [TDATA_W-1:0] m_axis_tdata,   // [DATA_WIDTH-1:0] sorted_value
    output logic                    m_axis_tlast,   // final_result
    output logic                    m_axis_tuser    // [0] overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 1;
    localparam int KW = 2 * CW;

    qsh_stat_t stat;
    qsh_ctl_t  ctl;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic signed [IW-1:0] i_reg, i_next;
    logic signed [IW-1:0] j_reg, j_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [DATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic signed [IW-1:0] lo_s, hi_m1_s, i_p1, j_m1, j_p1;
    logic [CW-1:0]        k_p1, sp_m1;
    logic [CW:0]          mid_sum, mid;
    logic [CW-1:0]        rd_lo, rd_hi;

    logic                  st_we;
    logic [AW-1:0]         st_waddr, st_raddr;
    logic [DATA_WIDTH-1:0] st_wdata, st_rdata;
    logic [KW-1:0]         stk_wdata, stk_rdata;

    qsh_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    qsh_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (ctl.stk_we),
        .waddr (sp_reg[AW-1:0]),
        .wdata (stk_wdata),
        .raddr (sp_m1[AW-1:0]),
        .rdata (stk_rdata)
    );

    qsh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    assign lo_s    = $signed({1'b0, lo_reg});
    assign hi_m1_s = $signed({1'b0, hi_reg}) - $signed(IW'(1));
    assign i_p1    = i_reg + $signed(IW'(1));
    assign j_m1    = j_reg - $signed(IW'(1));
    assign j_p1    = j_reg + $signed(IW'(1));
    assign k_p1    = k_reg + CW'(1);
    assign sp_m1   = sp_reg - CW'(1);

    // stack entry: lo in the low half, hi in the high half
    assign rd_lo   = stk_rdata[CW-1:0];
    assign rd_hi   = stk_rdata[KW-1:CW];
    assign mid_sum = {1'b0, rd_lo} + {1'b0, rd_hi} - (CW+1)'(1);
    assign mid     = mid_sum >> 1;

    always_comb begin
        stat.in_fire     = s_axis_tvalid && ctl.in_ready;
        stat.in_last     = s_axis_tlast;
        stat.room        = cnt_reg < CW'(DEPTH);
        stat.cnt_ge2     = cnt_reg >= CW'(2);
        stat.stk_empty   = sp_reg == '0;
        stat.range_short = ({1'b0, rd_lo} + (CW+1)'(1)) >= {1'b0, rd_hi};
        stat.i_adv       = (i_reg < hi_m1_s) && ($signed(st_rdata) < $signed(key_reg));
        stat.j_adv       = (j_reg > lo_s) && ($signed(st_rdata) > $signed(key_reg));
        stat.not_crossed = i_reg <= j_reg;
        stat.swap_more   = i_p1 <= j_m1;
        stat.upper_ok    = (i_reg < hi_m1_s) && (sp_reg < CW'(DEPTH));
        stat.lower_ok    = (j_reg > lo_s) && (sp_reg < CW'(DEPTH));
        stat.out_fire    = m_axis_tready && ctl.out_valid;
        stat.out_last    = out_last_reg;
    end

    always_comb begin
        unique case (ctl.st_rsel)
            SRD_MID:   st_raddr = mid[AW-1:0];
            SRD_I:     st_raddr = i_reg[AW-1:0];
            SRD_I_INC: st_raddr = i_p1[AW-1:0];
            SRD_J:     st_raddr = j_reg[AW-1:0];
            SRD_J_DEC: st_raddr = j_m1[AW-1:0];
            SRD_K:     st_raddr = k_reg[AW-1:0];
            SRD_K_INC: st_raddr = k_p1[AW-1:0];
            default:   st_raddr = k_reg[AW-1:0];
        endcase
    end

    always_comb begin
        st_we = ctl.st_we;
        unique case (ctl.st_wsel)
            SWR_IN: begin
                st_waddr = cnt_reg[AW-1:0];
                st_wdata = s_axis_tdata[DATA_WIDTH-1:0];
            end
            SWR_I: begin
                st_waddr = i_reg[AW-1:0];
                st_wdata = b_reg;
            end
            SWR_J: begin
                st_waddr = j_reg[AW-1:0];
                st_wdata = a_reg;
            end
            default: begin
                st_waddr = cnt_reg[AW-1:0];
                st_wdata = s_axis_tdata[DATA_WIDTH-1:0];
            end
        endcase
    end

    always_comb begin
        unique case (ctl.stk_wsel)
            KWR_FULL:  stk_wdata = {cnt_reg, CW'(0)};
            KWR_UPPER: stk_wdata = {hi_reg, i_reg[CW-1:0]};
            KWR_LOWER: stk_wdata = {j_p1[CW-1:0], lo_reg};
            default:   stk_wdata = {cnt_reg, CW'(0)};
        endcase
    end

    always_comb begin
        cnt_next      = cnt_reg;
        drop_next     = drop_reg;
        sp_next       = sp_reg;
        k_next        = k_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        key_next      = key_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_ovf_next  = out_ovf_reg;

        if (ctl.cnt_inc) begin
            cnt_next = cnt_reg + CW'(1);
        end
        if (ctl.drop_set) begin
            drop_next = 1'b1;
        end
        if (ctl.sp_inc) begin
            sp_next = sp_reg + CW'(1);
        end
        if (ctl.sp_dec) begin
            sp_next = sp_m1;
        end
        if (ctl.k_inc) begin
            k_next = k_p1;
        end
        if (ctl.ld_range) begin
            lo_next = rd_lo;
            hi_next = rd_hi;
            i_next  = $signed({1'b0, rd_lo});
            j_next  = $signed({1'b0, rd_hi}) - $signed(IW'(1));
        end
        if (ctl.i_inc) begin
            i_next = i_p1;
        end
        if (ctl.j_dec) begin
            j_next = j_m1;
        end
        if (ctl.ld_key) begin
            key_next = st_rdata;
        end
        if (ctl.ld_a) begin
            a_next = st_rdata;
        end
        if (ctl.ld_b) begin
            b_next = st_rdata;
        end
        if (ctl.ld_out) begin
            out_data_next = st_rdata;
            out_last_next = k_p1 == cnt_reg;
            out_ovf_next  = drop_reg;
        end
        // last result taken: start the next set
        if (ctl.clr_set) begin
            cnt_next  = '0;
            drop_next = 1'b0;
            sp_next   = '0;
            k_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
            sp_reg   <= '0;
            k_reg    <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
            sp_reg   <= sp_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        key_reg      <= key_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign s_axis_tready = ctl.in_ready;
    assign m_axis_tvalid = ctl.out_valid;
    assign m_axis_tdata  = TDATA_W'(out_data_reg);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

    `QSH_ASSERT(a_no_in_during_out, aclk, aresetn,
        !(m_axis_tvalid && s_axis_tready), "input ready while a result is offered")
    `QSH_ASSERT_NEXT(a_last_in_blocks, aclk, aresetn,
        s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready,
        "input still ready after final item")
    `QSH_ASSERT_NEXT(a_last_out_clears, aclk, aresetn,
        m_axis_tvalid && m_axis_tready && m_axis_tlast,
        (cnt_reg == '0) && (sp_reg == '0) && !drop_reg,
        "set state not cleared after last result")
    `QSH_ASSERT(a_swap_uncrossed, aclk, aresetn,
        !(ctl.st_we && (ctl.st_wsel == SWR_I)) || (i_reg <= j_reg),
        "swap with crossed indices")

endmodule

`default_nettype wire

### dv/qsh_sorted_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsh_sorted_stream_checker
// Watches both streams of the quicksort block, predicts each sorted run and
// compares every result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module qsh_sorted_stream_checker
    import qsh_pkg::*;
#(
    parameter int DEPTH     = QSH_DEPTH,
    parameter int DW        = QSH_DATA_WIDTH,
    localparam int TDATA_W  = ((DW + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_axis_tvalid,
    input  wire logic               s_axis_tready,
    input  wire logic [TDATA_W-1:0] s_axis_tdata,   // [DW-1:0] data_value
    input  wire logic               s_axis_tlast,   // final_item
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [TDATA_W-1:0] m_axis_tdata,   // [DW-1:0] sorted_value
    input  wire logic               m_axis_tlast,   // final_result
    input  wire logic               m_axis_tuser,   // [0] overflow
    output int                      mismatch_count,
    output int                      outstanding
);

    typedef struct packed {
        logic [DW-1:0] value;
        logic          last;
        logic          overflow;
    } sorted_result_t;

    // set under collection, kept in ascending order as items arrive
    logic signed [DW-1:0] held_set[$];
    bit                   held_dropped;
    sorted_result_t       sorted_expect_q[$];
    int                   errors;

    always @(posedge aclk) begin : track
        logic signed [DW-1:0] v;
        sorted_result_t       want;
        int                   pos;
        int                   k;
        if (!aresetn) begin
            held_set.delete();
            sorted_expect_q.delete();
            held_dropped = 1'b0;
            errors = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                v = s_axis_tdata[DW-1:0];
                if (held_set.size() < DEPTH) begin
                    pos = 0;
                    while (pos < held_set.size() && held_set[pos] <= v)
                        pos++;
                    held_set.insert(pos, v);
                end else begin
                    held_dropped = 1'b1;
                end
                if (s_axis_tlast) begin
                    for (k = 0; k < held_set.size(); k++) begin
                        want.value    = held_set[k];
                        want.last     = (k == held_set.size() - 1);
                        want.overflow = held_dropped;
                        sorted_expect_q.push_back(want);
                    end
                    held_set.delete();
                    held_dropped = 1'b0;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (sorted_expect_q.size() == 0) begin
                    $error("unexpected result item: sorted_value %0d",
                           $signed(m_axis_tdata[DW-1:0]));
                    errors++;
                end else begin
                    want = sorted_expect_q.pop_front();
                    if (m_axis_tdata[DW-1:0] !== want.value) begin
                        $error("sorted_value: expected %0d, got %0d",
                               $signed(want.value), $signed(m_axis_tdata[DW-1:0]));
                        errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("final_result: expected %0b, got %0b",
                               want.last, m_axis_tlast);
                        errors++;
                    end
                    if (m_axis_tuser !== want.overflow) begin
                        $error("overflow: expected %0b, got %0b",
                               want.overflow, m_axis_tuser);
                        errors++;
                    end
                end
            end
        end
        mismatch_count <= errors;
        outstanding    <= sorted_expect_q.size();
    end

endmodule

### dv/tb_quicksort_hoare_block.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quicksort_hoare_block
// Stimulus and verdict for the quicksort block: directed sets for extremes,
// duplicates and reversed order, then random sets of mixed size, some full
// and some over capacity, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_quicksort_hoare_block;
    import qsh_pkg::*;

    localparam int DEPTH          = QSH_DEPTH;
    localparam int DW             = QSH_DATA_WIDTH;
    localparam int TDATA_W        = ((DW + 7) / 8) * 8;
    localparam int RANDOM_ITEMS   = 500;
    localparam int LONG_HOLD      = 600;
    localparam int TAIL_CYCLES    = 64;

    typedef enum int {
        VAL_FULL,
        VAL_NARROW,
        VAL_EXTREME,
        VAL_RISING,
        VAL_FALLING
    } value_mode_t;

    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;
    logic               m_axis_tuser;
    int                 mismatch_count;
    int                 outstanding;

    logic signed [DW-1:0] set_buf[$];
    int                   items_sent;
    int                   sets_sent;
    int                   overflow_sets;
    int                   largest_set;
    int                   results_taken;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    quicksort_hoare_block DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    qsh_sorted_stream_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    function automatic logic signed [DW-1:0] draw_value(input value_mode_t mode,
                                                        input int idx,
                                                        input logic signed [DW-1:0] base);
        int pick;
        pick = $urandom_range(0, 15);
        case (mode)
            VAL_NARROW:  return DW'(pick - 8);
            VAL_EXTREME: begin
                case (pick % 6)
                    0:       return VMIN;
                    1:       return VMAX;
                    2:       return '0;
                    3:       return '1;
                    4:       return DW'(1);
                    default: return VMIN + DW'(1);
                endcase
            end
            VAL_RISING:  return base + DW'(idx);
            VAL_FALLING: return base - DW'(idx);
            default:     return DW'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic signed [DW-1:0] v, input bit fin,
                             input int unsigned gap);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'($unsigned(v));
        s_axis_tlast  <= fin;
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        items_sent++;
    endtask

    // send set_buf as one run, tlast on its final item
    task automatic send_set(input bit burst);
        int k;
        for (k = 0; k < set_buf.size(); k++)
            send_item(set_buf[k], k == set_buf.size() - 1,
                      burst ? 0 : $urandom_range(0, 11));
        sets_sent++;
        if (set_buf.size() > DEPTH)
            overflow_sets++;
        if (set_buf.size() > largest_set)
            largest_set = set_buf.size();
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin : stimulus
        int          n;
        int          k;
        int          r;
        int          rnd_sets;
        int          rnd_start;
        value_mode_t mode;
        logic signed [DW-1:0] base;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        items_sent    = 0;
        sets_sent     = 0;
        overflow_sets = 0;
        largest_set   = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single element
        set_buf = '{VMAX};
        send_set(1'b0);
        // field extremes and alternating bit patterns
        set_buf = '{VMIN, VMAX, '0, '1, DW'(1), VMIN + DW'(1), VMAX - DW'(1),
                    {(DW/2){2'b01}}, {(DW/2){2'b10}}};
        send_set(1'b1);
        // duplicates of one value, the first pivot being the only other value
        set_buf = '{DW'(3), DW'(3), -DW'(3), DW'(3), DW'(3)};
        send_set(1'b0);
        // reversed order across zero
        set_buf = '{DW'(2), DW'(1), DW'(0), -DW'(1), -DW'(2), -DW'(3)};
        send_set(1'b0);
        wait_drained();

        rnd_sets  = 0;
        rnd_start = items_sent;
        while (items_sent - rnd_start < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                n = $urandom_range(1, 12);
            else if (r < 88)
                n = $urandom_range(13, DEPTH - 1);
            else
                n = $urandom_range(DEPTH, DEPTH + 6);
            // make sure one set fills the store exactly and one spills over
            if (rnd_sets == 1)
                n = DEPTH;
            else if (rnd_sets == 4)
                n = DEPTH + 3;
            r = $urandom_range(0, 9);
            mode = (r < 6) ? VAL_FULL : value_mode_t'(r - 5);
            base = DW'($urandom);
            set_buf.delete();
            for (k = 0; k < n; k++)
                set_buf.push_back(draw_value(mode, k, base));
            send_set($urandom_range(0, 3) == 0);
            rnd_sets++;
            if (rnd_sets % 9 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d items in %0d sets, %0d of them over capacity, largest %0d.",
                 items_sent, sets_sent, overflow_sets, largest_set);
        $display("Checked %0d sorted results, %0d field mismatches.",
                 results_taken, mismatch_count);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned stall;
        bit          burst;
        results_taken = 0;
        burst         = 1'b0;
        m_axis_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (results_taken % 16 == 0)
                burst = ($urandom_range(0, 3) == 0);
            // hold off long enough for the input side to back up
            if (results_taken == 30 || results_taken == 300)
                stall = LONG_HOLD;
            else if (burst)
                stall = 0;
            else
                stall = $urandom_range(0, 11);
            repeat (stall) begin
                m_axis_tready <= 1'b0;
                @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            results_taken++;
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/qsh_pkg.sv
hw/rtl/qsh_ram.sv
hw/rtl/qsh_ctrl.sv
hw/rtl/quicksort_hoare_block.sv
dv/qsh_sorted_stream_checker.sv
dv/tb_quicksort_hoare_block.sv
